/* rtl/rtc_pkg.sv */
// Package for the thresholded region-of-interest centroid block.
// Holds the word types, register indexes, reset values and fixed widths.
// No dependencies; every other file but the stream interface uses it by scoped names.
package rtc_pkg;

    // Fixed field widths
    localparam int CH_W       = 8;
    localparam int SIZE_W     = 11;
    localparam int OFS_W      = 10;
    localparam int LEVEL_W    = 8;
    localparam int CNT_W      = 21;
    localparam int SUM_W      = 30;
    localparam int CEN_W      = 18;
    localparam int FRAC_BITS  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // Marking of a counted pixel and the divisor of the channel mean
    localparam logic [CH_W-1:0] HIT_BLUE  = 8'd128;
    localparam logic [CH_W-1:0] HIT_GREEN = 8'd255;
    localparam int              MEAN_DIV  = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROI_LEFT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROI_TOP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROI_WIDTH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROI_HEIGHT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL        = 3'd6;

    // Register reset values
    localparam logic [SIZE_W-1:0]  RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [SIZE_W-1:0]  RST_IMAGE_HEIGHT = 11'd480;
    localparam logic [OFS_W-1:0]   RST_ROI_LEFT     = 10'd20;
    localparam logic [OFS_W-1:0]   RST_ROI_TOP      = 10'd10;
    localparam logic [SIZE_W-1:0]  RST_ROI_WIDTH    = 11'd80;
    localparam logic [SIZE_W-1:0]  RST_ROI_HEIGHT   = 11'd100;
    localparam logic [LEVEL_W-1:0] RST_LEVEL        = 8'd100;

    typedef struct packed {
        logic [SIZE_W-1:0]  image_width;
        logic [SIZE_W-1:0]  image_height;
        logic [OFS_W-1:0]   roi_left;
        logic [OFS_W-1:0]   roi_top;
        logic [SIZE_W-1:0]  roi_width;
        logic [SIZE_W-1:0]  roi_height;
        logic [LEVEL_W-1:0] level;
    } cfg_t;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } pix_t;

    typedef struct packed {
        logic [CH_W-1:0]  out_blue;
        logic [CH_W-1:0]  out_green;
        logic [CH_W-1:0]  out_red;
        logic             counted;
        logic             frame_done;
        logic [CEN_W-1:0] centroid_x;
        logic [CEN_W-1:0] centroid_y;
        logic [CNT_W-1:0] hit_total;
    } res_t;

    typedef struct packed {
        logic [CNT_W-1:0] hit_count;
        logic [SUM_W-1:0] sum_col;
        logic [SUM_W-1:0] sum_row;
    } acc_t;

    typedef struct packed {
        logic hit;
        logic done;
    } pix_stat_t;

endpackage

/* rtl/rtc_stream_if.sv */
// Valid/ready stream interface carrying one word of a given payload type.
// Used for the pixel input and the result output; no dependencies.
interface rtc_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/rtc_div.sv */
// Shared restoring divider: (sum * 256 + count / 2) / count, one bit a cycle.
// Depends on rtc_pkg for the fixed widths.
module rtc_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [rtc_pkg::SUM_W-1:0]     sum,
    input  logic [rtc_pkg::CNT_W-1:0]     count,
    output logic                          done,
    output logic [rtc_pkg::CEN_W-1:0]     quot
);
    localparam int NUM_W  = rtc_pkg::SUM_W + rtc_pkg::FRAC_BITS;
    localparam int STEP_W = $clog2(NUM_W);
    localparam int DW     = rtc_pkg::CNT_W;

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [NUM_W-1:0]      num_reg;
    logic [DW-1:0]         rem_reg;
    logic [DW-1:0]         div_reg;
    logic [rtc_pkg::CEN_W-1:0] quot_reg;

    logic [NUM_W-1:0]      numerator;
    logic [DW:0]           trial;
    logic                  fits;
    logic [DW-1:0]         rem_next;
    logic                  last_step;

    // Rounded numerator formed once at start.
    assign numerator = {sum, {rtc_pkg::FRAC_BITS{1'b0}}} + NUM_W'(count >> 1);

    // One restoring step: shift in the next numerator bit and try a subtract.
    assign trial     = {rem_reg, num_reg[NUM_W-1]};
    assign fits      = trial >= {1'b0, div_reg};
    assign rem_next  = fits ? DW'(trial - {1'b0, div_reg}) : trial[DW-1:0];
    assign last_step = step_reg == STEP_W'(NUM_W - 1);

    // Sequencing of the steps.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                busy_reg <= !last_step;
                step_reg <= step_reg + STEP_W'(1);
            end
        end
    end

    // Datapath of the divider.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= numerator;
            rem_reg  <= '0;
            div_reg  <= count;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg  <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[rtc_pkg::CEN_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

/* rtl/rtc_pixel.sv */
// Raster position counters, clamped region test, threshold and running sums.
// Depends on rtc_pkg for the configuration, pixel and accumulator types.
module rtc_pixel #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  rtc_pkg::cfg_t      cfg,
    input  logic               step,
    input  rtc_pkg::pix_t      pix_in,
    output rtc_pkg::pix_stat_t stat,
    output rtc_pkg::acc_t      acc_upd
);
    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int GXW = (XW + 2 > rtc_pkg::SIZE_W + 1) ? XW + 2 : rtc_pkg::SIZE_W + 1;
    localparam int GYW = (YW + 2 > rtc_pkg::SIZE_W + 1) ? YW + 2 : rtc_pkg::SIZE_W + 1;
    localparam int MW  = rtc_pkg::CH_W + 2;

    logic [XW-1:0]  col_reg, col_next;
    logic [YW-1:0]  row_reg, row_next;
    rtc_pkg::acc_t  acc_reg, acc_next;

    logic [GXW-1:0] w_raw, w_lim, w_last, x0, x_end, x1, col_ext;
    logic [GYW-1:0] h_raw, h_lim, h_last, y0, y_end, y1, row_ext;
    logic [MW-1:0]  chan_sum, thr;
    logic           in_region, hit, line_end, done;

    // Image size limited to 1..MAX, region clamped into the image.
    always_comb
    begin
        w_raw = GXW'(cfg.image_width);
        if (w_raw == '0)
            w_lim = GXW'(1);
        else if (w_raw > GXW'(MAX_WIDTH))
            w_lim = GXW'(MAX_WIDTH);
        else
            w_lim = w_raw;
        w_last = w_lim - GXW'(1);
        x0     = (GXW'(cfg.roi_left) < w_last) ? GXW'(cfg.roi_left) : w_last;
        x_end  = x0 + GXW'(cfg.roi_width);
        x1     = (x_end > w_lim) ? w_lim : x_end;

        h_raw = GYW'(cfg.image_height);
        if (h_raw == '0)
            h_lim = GYW'(1);
        else if (h_raw > GYW'(MAX_HEIGHT))
            h_lim = GYW'(MAX_HEIGHT);
        else
            h_lim = h_raw;
        h_last = h_lim - GYW'(1);
        y0     = (GYW'(cfg.roi_top) < h_last) ? GYW'(cfg.roi_top) : h_last;
        y_end  = y0 + GYW'(cfg.roi_height);
        y1     = (y_end > h_lim) ? h_lim : y_end;
    end

    // Region test and threshold: floor(sum / 3) > level means sum >= 3 * (level + 1).
    assign col_ext   = GXW'(col_reg);
    assign row_ext   = GYW'(row_reg);
    assign in_region = (col_ext >= x0) && (col_ext < x1)
                       && (row_ext >= y0) && (row_ext < y1);
    assign chan_sum  = MW'(pix_in.blue) + MW'(pix_in.green) + MW'(pix_in.red);
    assign thr       = MW'(rtc_pkg::MEAN_DIV) * (MW'(cfg.level) + MW'(1));
    assign hit       = in_region && (chan_sum >= thr);
    assign line_end  = col_ext >= w_last;
    assign done      = line_end && (row_ext >= h_last);

    assign stat.hit  = hit;
    assign stat.done = done;

    // Sums including the present pixel.
    always_comb
    begin
        acc_upd = acc_reg;
        if (hit)
        begin
            acc_upd.hit_count = acc_reg.hit_count + rtc_pkg::CNT_W'(1);
            acc_upd.sum_col   = acc_reg.sum_col + rtc_pkg::SUM_W'(col_reg);
            acc_upd.sum_row   = acc_reg.sum_row + rtc_pkg::SUM_W'(row_reg);
        end
    end

    // Next position and accumulator state for an accepted pixel.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        acc_next = acc_reg;
        if (step)
        begin
            acc_next = done ? '0 : acc_upd;
            if (line_end)
            begin
                col_next = '0;
                row_next = done ? '0 : row_reg + YW'(1);
            end
            else
            begin
                col_next = col_reg + XW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            acc_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            acc_reg <= acc_next;
        end
    end

endmodule

/* rtl/roi_threshold_centroid.sv */
// Top level of the thresholded region-of-interest centroid block.
// Depends on rtc_pkg, rtc_stream_if, rtc_pixel and rtc_div.
//
// Usage:
//   pix carries one smoothed BGR pixel per word in raster order; res returns
//   one word per pixel: the pixel (marked blue 128, green 255 when counted),
//   the counted flag and, on the last pixel of a frame, the frame-done flag,
//   the centroid in 1/256 pixel and the number of counted pixels.
//   Registers are written through cfg_we, cfg_index and cfg_data while idle.
// Flow:
//   An ordinary pixel is in the output register in the cycle after acceptance,
//   and a new pixel is taken every cycle while the output register can move.
//   The last pixel of a frame with counted pixels runs two divisions on the
//   one shared restoring divider, one quotient bit a cycle over 38 steps:
//   its word comes out once both quotients are in, and no pixel is taken
//   meanwhile. A frame with no counted pixel skips the divisions.
// Reset: registers return to their defaults, counters and sums clear.
// Stall: a word waits in the output register until taken; pix.ready stays
//   low while that register is full and not being emptied.
module roi_threshold_centroid #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    rtc_stream_if.sink                        pix,
    rtc_stream_if.source                      res,
    input  logic                              cfg_we,
    input  logic [rtc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rtc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_DIVX = 2'd1;
    localparam logic [1:0] ST_DIVY = 2'd2;
    localparam logic [1:0] ST_LOAD = 2'd3;

    rtc_pkg::cfg_t      cfg_reg;
    logic [1:0]         state_reg, state_next;
    logic               out_valid_reg, out_valid_next;
    rtc_pkg::res_t      res_reg, res_next;
    rtc_pkg::res_t      hold_reg, hold_next;
    logic [rtc_pkg::SUM_W-1:0] hold_sum_row_reg, hold_sum_row_next;
    logic [rtc_pkg::CNT_W-1:0] hold_cnt_reg, hold_cnt_next;

    rtc_pkg::pix_t      pix_word;
    rtc_pkg::pix_stat_t stat;
    rtc_pkg::acc_t      acc_upd;
    rtc_pkg::res_t      pix_res;
    logic               out_free, pix_step, frame_hits;
    logic               div_start, div_done;
    logic [rtc_pkg::SUM_W-1:0] div_sum;
    logic [rtc_pkg::CNT_W-1:0] div_cnt;
    logic [rtc_pkg::CEN_W-1:0] div_quot;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= rtc_pkg::RST_IMAGE_WIDTH;
            cfg_reg.image_height <= rtc_pkg::RST_IMAGE_HEIGHT;
            cfg_reg.roi_left     <= rtc_pkg::RST_ROI_LEFT;
            cfg_reg.roi_top      <= rtc_pkg::RST_ROI_TOP;
            cfg_reg.roi_width    <= rtc_pkg::RST_ROI_WIDTH;
            cfg_reg.roi_height   <= rtc_pkg::RST_ROI_HEIGHT;
            cfg_reg.level        <= rtc_pkg::RST_LEVEL;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rtc_pkg::REG_IMAGE_WIDTH:  cfg_reg.image_width  <= cfg_data;
                rtc_pkg::REG_IMAGE_HEIGHT: cfg_reg.image_height <= cfg_data;
                rtc_pkg::REG_ROI_LEFT:     cfg_reg.roi_left     <= cfg_data[rtc_pkg::OFS_W-1:0];
                rtc_pkg::REG_ROI_TOP:      cfg_reg.roi_top      <= cfg_data[rtc_pkg::OFS_W-1:0];
                rtc_pkg::REG_ROI_WIDTH:    cfg_reg.roi_width    <= cfg_data;
                rtc_pkg::REG_ROI_HEIGHT:   cfg_reg.roi_height   <= cfg_data;
                rtc_pkg::REG_LEVEL:        cfg_reg.level        <= cfg_data[rtc_pkg::LEVEL_W-1:0];
                default:                   ;
            endcase
        end
    end

    // Input handshake: one pixel a cycle while running and the output can move.
    assign out_free  = !out_valid_reg || res.ready;
    assign pix.ready = (state_reg == ST_RUN) && out_free;
    assign pix_step  = pix.valid && pix.ready;
    assign pix_word  = pix.payload;

    rtc_pixel #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_pixel (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .step    (pix_step),
        .pix_in  (pix_word),
        .stat    (stat),
        .acc_upd (acc_upd)
    );

    // Result word for the present pixel, centroid fields still zero.
    always_comb
    begin
        pix_res            = '0;
        pix_res.out_blue   = stat.hit ? rtc_pkg::HIT_BLUE : pix_word.blue;
        pix_res.out_green  = stat.hit ? rtc_pkg::HIT_GREEN : pix_word.green;
        pix_res.out_red    = pix_word.red;
        pix_res.counted    = stat.hit;
        pix_res.frame_done = stat.done;
        pix_res.hit_total  = stat.done ? acc_upd.hit_count : '0;
    end

    assign frame_hits = acc_upd.hit_count != '0;

    // The divider takes the column sum first, then the held row sum.
    assign div_start = (state_reg == ST_RUN) ? (pix_step && stat.done && frame_hits)
                                             : ((state_reg == ST_DIVX) && div_done);
    assign div_sum   = (state_reg == ST_RUN) ? acc_upd.sum_col : hold_sum_row_reg;
    assign div_cnt   = (state_reg == ST_RUN) ? acc_upd.hit_count : hold_cnt_reg;

    rtc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .sum   (div_sum),
        .count (div_cnt),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Sequencer and output register control.
    always_comb
    begin
        state_next        = state_reg;
        out_valid_next    = out_valid_reg && !res.ready;
        res_next          = res_reg;
        hold_next         = hold_reg;
        hold_sum_row_next = hold_sum_row_reg;
        hold_cnt_next     = hold_cnt_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (pix_step)
                begin
                    if (stat.done && frame_hits)
                    begin
                        hold_next         = pix_res;
                        hold_sum_row_next = acc_upd.sum_row;
                        hold_cnt_next     = acc_upd.hit_count;
                        state_next        = ST_DIVX;
                    end
                    else
                    begin
                        res_next       = pix_res;
                        out_valid_next = 1'b1;
                    end
                end
            end
            ST_DIVX:
            begin
                if (div_done)
                begin
                    hold_next.centroid_x = div_quot;
                    state_next           = ST_DIVY;
                end
            end
            ST_DIVY:
            begin
                if (div_done)
                begin
                    hold_next.centroid_y = div_quot;
                    state_next           = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    res_next       = hold_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        res_reg          <= res_next;
        hold_reg         <= hold_next;
        hold_sum_row_reg <= hold_sum_row_next;
        hold_cnt_reg     <= hold_cnt_next;
    end

    assign res.valid   = out_valid_reg;
    assign res.payload = res_reg;

`ifndef SYNTHESIS
    // No pixel is taken while a frame result is being worked out.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_RUN) |-> !pix.ready)
        else $error("pixel input ready outside the running state");

    // A quotient only arrives while the sequencer waits for one.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> ((state_reg == ST_DIVX) || (state_reg == ST_DIVY)))
        else $error("divider finished outside a division state");

    // The last pixel of a frame either goes straight out or starts the division.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pix_step && stat.done) |=> ((state_reg == ST_DIVX) || out_valid_reg))
        else $error("last pixel of frame neither sent nor divided");
`endif

endmodule

/* bench/rtc_centroid_checker.sv */
`timescale 1ns / 100ps
// Checker for the region-of-interest centroid block: watches the pixel, result and register
// channels, keeps its own copy of the counters and sums, and compares every result word.
// Depends on rtc_pkg for the word types, register indexes and reset values.
module rtc_centroid_checker #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           pix_valid,
    input  logic                           pix_ready,
    input  rtc_pkg::pix_t                  pix_word,
    input  logic                           res_valid,
    input  logic                           res_ready,
    input  rtc_pkg::res_t                  res_word,
    input  logic                           cfg_we,
    input  logic [rtc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rtc_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             waiting
);
    // Register copy, raster position and running sums of the current frame.
    rtc_pkg::cfg_t             setting;
    logic [rtc_pkg::OFS_W-1:0] column;
    logic [rtc_pkg::OFS_W-1:0] row;
    rtc_pkg::acc_t             acc;
    rtc_pkg::res_t             expected_words[$];
    int                        fails = 0;

    assign fail_count = fails;

    // A size of zero counts as one; anything beyond the maximum is cut to it.
    function automatic int unsigned size_clip(input int unsigned v, input int unsigned limit);
        if (v < 1)
            return 1;
        if (v > limit)
            return limit;
        return v;
    endfunction

    // Centroid in 1/256 pixel, rounded to nearest with ties upward.
    function automatic logic [rtc_pkg::CEN_W-1:0] centroid_of(
        input logic [rtc_pkg::SUM_W-1:0] total,
        input logic [rtc_pkg::CNT_W-1:0] n);
        logic [63:0] num;
        logic [63:0] quo;
        if (n == '0)
            return '0;
        num = ({34'd0, total} << rtc_pkg::FRAC_BITS) + 64'(n >> 1);
        quo = num / 64'(n);
        return quo[rtc_pkg::CEN_W-1:0];
    endfunction

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setting = '{rtc_pkg::RST_IMAGE_WIDTH, rtc_pkg::RST_IMAGE_HEIGHT,
                        rtc_pkg::RST_ROI_LEFT, rtc_pkg::RST_ROI_TOP,
                        rtc_pkg::RST_ROI_WIDTH, rtc_pkg::RST_ROI_HEIGHT,
                        rtc_pkg::RST_LEVEL};
            column = '0;
            row = '0;
            acc = '0;
            expected_words.delete();
            waiting <= 0;
        end
        else
        begin : track
            rtc_pkg::res_t want;
            int unsigned   wid;
            int unsigned   hgt;
            int unsigned   x0;
            int unsigned   y0;
            int unsigned   x1;
            int unsigned   y1;
            int unsigned   mean;
            logic          hit;
            logic          line_end;
            logic          done;

            // The result side goes first: its word always predates a pixel taken now.
            if (res_valid && res_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("result word arrived with no pixel outstanding");
                    fails++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("out_blue", want.out_blue, res_word.out_blue);
                    check_field("out_green", want.out_green, res_word.out_green);
                    check_field("out_red", want.out_red, res_word.out_red);
                    check_field("counted", want.counted, res_word.counted);
                    check_field("frame_done", want.frame_done, res_word.frame_done);
                    check_field("centroid_x", want.centroid_x, res_word.centroid_x);
                    check_field("centroid_y", want.centroid_y, res_word.centroid_y);
                    check_field("hit_total", want.hit_total, res_word.hit_total);
                end
            end

            // Predict the word for an accepted pixel and advance the raster position.
            if (pix_valid && pix_ready)
            begin
                wid = size_clip(setting.image_width, MAX_WIDTH);
                hgt = size_clip(setting.image_height, MAX_HEIGHT);
                x0 = (setting.roi_left < wid - 1) ? setting.roi_left : wid - 1;
                y0 = (setting.roi_top < hgt - 1) ? setting.roi_top : hgt - 1;
                x1 = (x0 + setting.roi_width > wid) ? wid : x0 + setting.roi_width;
                y1 = (y0 + setting.roi_height > hgt) ? hgt : y0 + setting.roi_height;
                mean = (32'(pix_word.blue) + 32'(pix_word.green) + 32'(pix_word.red))
                       / rtc_pkg::MEAN_DIV;
                hit = (column >= x0) && (column < x1) && (row >= y0) && (row < y1)
                      && (mean > setting.level);

                if (hit)
                begin
                    acc.hit_count = acc.hit_count + 1'b1;
                    acc.sum_col = acc.sum_col + rtc_pkg::SUM_W'(column);
                    acc.sum_row = acc.sum_row + rtc_pkg::SUM_W'(row);
                end

                line_end = (column >= wid - 1);
                done = line_end && (row >= hgt - 1);

                want.out_blue = hit ? rtc_pkg::HIT_BLUE : pix_word.blue;
                want.out_green = hit ? rtc_pkg::HIT_GREEN : pix_word.green;
                want.out_red = pix_word.red;
                want.counted = hit;
                want.frame_done = done;
                if (done)
                begin
                    want.centroid_x = centroid_of(acc.sum_col, acc.hit_count);
                    want.centroid_y = centroid_of(acc.sum_row, acc.hit_count);
                    want.hit_total = acc.hit_count;
                    acc = '0;
                end
                else
                begin
                    want.centroid_x = '0;
                    want.centroid_y = '0;
                    want.hit_total = '0;
                end
                expected_words.push_back(want);

                if (line_end)
                begin
                    column = '0;
                    row = done ? '0 : row + 1'b1;
                end
                else
                    column = column + 1'b1;
            end

            // Register writes, cut to each register's width.
            if (cfg_we)
            begin
                case (cfg_index)
                    rtc_pkg::REG_IMAGE_WIDTH:
                        setting.image_width = cfg_data[rtc_pkg::SIZE_W-1:0];
                    rtc_pkg::REG_IMAGE_HEIGHT:
                        setting.image_height = cfg_data[rtc_pkg::SIZE_W-1:0];
                    rtc_pkg::REG_ROI_LEFT:
                        setting.roi_left = cfg_data[rtc_pkg::OFS_W-1:0];
                    rtc_pkg::REG_ROI_TOP:
                        setting.roi_top = cfg_data[rtc_pkg::OFS_W-1:0];
                    rtc_pkg::REG_ROI_WIDTH:
                        setting.roi_width = cfg_data[rtc_pkg::SIZE_W-1:0];
                    rtc_pkg::REG_ROI_HEIGHT:
                        setting.roi_height = cfg_data[rtc_pkg::SIZE_W-1:0];
                    rtc_pkg::REG_LEVEL:
                        setting.level = cfg_data[rtc_pkg::LEVEL_W-1:0];
                    default: ;
                endcase
            end

            waiting <= expected_words.size();
        end
    end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// Top of the centroid testbench: clock, reset, register set-up, pixel stimulus, result
// back-pressure and the verdict. Depends on rtc_pkg, rtc_stream_if, the block and the checker.
module testbench;
    localparam int MAX_DIM      = 1024;
    localparam int PIXEL_TARGET = 1500;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef enum int {DRAIN_FREE, DRAIN_CADENCE, DRAIN_SPARSE, DRAIN_LONG} drain_mode_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we;
    logic [rtc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [rtc_pkg::CFG_DATA_W-1:0] cfg_data;
    int                             fail_count;
    int                             waiting;
    int                             cycles = 0;
    int                             pixels_sent = 0;
    int                             drain_tick = 0;
    drain_mode_t                    drain_mode = DRAIN_FREE;
    rtc_pkg::cfg_t                  shadow;

    rtc_stream_if #(.payload_t(rtc_pkg::pix_t)) pix_if ();
    rtc_stream_if #(.payload_t(rtc_pkg::res_t)) res_if ();

    roi_threshold_centroid #(
        .MAX_WIDTH  (MAX_DIM),
        .MAX_HEIGHT (MAX_DIM)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix_if),
        .res       (res_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rtc_centroid_checker #(
        .MAX_WIDTH  (MAX_DIM),
        .MAX_HEIGHT (MAX_DIM)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_if.valid),
        .pix_ready  (pix_if.ready),
        .pix_word   (pix_if.payload),
        .res_valid  (res_if.valid),
        .res_ready  (res_if.ready),
        .res_word   (res_if.payload),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .waiting    (waiting)
    );

    always #2 clk = ~clk;

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // The result side stalls on one of four patterns, each picked at random by the drain tick.
    always @(posedge clk)
    begin
        if (!rst_n)
            res_if.ready <= 1'b0;
        else
        begin
            drain_tick <= drain_tick + 1;
            if (drain_tick % 64 == 63)
                drain_mode <= drain_mode_t'($urandom_range(0, 3));
            case (drain_mode)
                DRAIN_FREE:    res_if.ready <= 1'b1;
                DRAIN_CADENCE: res_if.ready <= (drain_tick % 3 != 0);
                DRAIN_SPARSE:  res_if.ready <= ($urandom_range(0, 3) == 0);
                default:       res_if.ready <= drain_tick[3];
            endcase
        end
    end

    task automatic put_reg(input logic [rtc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rtc_pkg::CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // Write the selected registers back to back; only called while the block is idle.
    task automatic write_regs(input rtc_pkg::cfg_t v, input logic [6:0] sel);
        if (sel[rtc_pkg::REG_IMAGE_WIDTH])
        begin
            put_reg(rtc_pkg::REG_IMAGE_WIDTH, v.image_width);
            shadow.image_width = v.image_width;
        end
        if (sel[rtc_pkg::REG_IMAGE_HEIGHT])
        begin
            put_reg(rtc_pkg::REG_IMAGE_HEIGHT, v.image_height);
            shadow.image_height = v.image_height;
        end
        if (sel[rtc_pkg::REG_ROI_LEFT])
        begin
            put_reg(rtc_pkg::REG_ROI_LEFT, rtc_pkg::CFG_DATA_W'(v.roi_left));
            shadow.roi_left = v.roi_left;
        end
        if (sel[rtc_pkg::REG_ROI_TOP])
        begin
            put_reg(rtc_pkg::REG_ROI_TOP, rtc_pkg::CFG_DATA_W'(v.roi_top));
            shadow.roi_top = v.roi_top;
        end
        if (sel[rtc_pkg::REG_ROI_WIDTH])
        begin
            put_reg(rtc_pkg::REG_ROI_WIDTH, v.roi_width);
            shadow.roi_width = v.roi_width;
        end
        if (sel[rtc_pkg::REG_ROI_HEIGHT])
        begin
            put_reg(rtc_pkg::REG_ROI_HEIGHT, v.roi_height);
            shadow.roi_height = v.roi_height;
        end
        if (sel[rtc_pkg::REG_LEVEL])
        begin
            put_reg(rtc_pkg::REG_LEVEL, rtc_pkg::CFG_DATA_W'(v.level));
            shadow.level = v.level;
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid and hold off until every expected word has come back.
    task automatic settle();
        pix_if.valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_word(input rtc_pkg::pix_t p);
        pix_if.valid <= 1'b1;
        pix_if.payload <= p;
        do
            @(posedge clk);
        while (!pix_if.ready);
        pixels_sent++;
    endtask

    // Mostly random bytes; some pixels sit on the level boundary or at the extremes.
    function automatic rtc_pkg::pix_t make_pixel();
        rtc_pkg::pix_t p;
        logic [31:0]   raw;
        int unsigned   pick;
        int unsigned   t;
        int unsigned   r;
        pick = $urandom_range(0, 9);
        raw = $urandom();
        p = raw[23:0];
        if (pick == 0)
        begin
            p.blue = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            p.green = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            p.red = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        end
        else if (pick < 4)
        begin
            t = 32'(shadow.level) + $urandom_range(0, 2);
            t = (t == 0) ? 0 : t - 1;
            if (t > 255)
                t = 255;
            r = t + $urandom_range(0, 2);
            if (r > 255)
                r = 255;
            p.blue = t[7:0];
            p.green = t[7:0];
            p.red = r[7:0];
        end
        return p;
    endfunction

    // Send a run of random pixels, in bursts with gaps between them unless told otherwise.
    task automatic send_run(input int n, input bit gaps_on);
        int burst_left;
        burst_left = $urandom_range(1, 24);
        for (int k = 0; k < n; k++)
        begin
            if (gaps_on && burst_left <= 0)
            begin
                pix_if.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = $urandom_range(1, 24);
            end
            send_word(make_pixel());
            burst_left--;
        end
    endtask

    // Mostly small images and regions, now and then the edge values of each register.
    function automatic rtc_pkg::cfg_t make_setting();
        rtc_pkg::cfg_t v;
        int unsigned   pick;
        pick = $urandom_range(0, 19);
        v.image_width = (pick == 0) ? rtc_pkg::SIZE_W'(0) :
                        (pick == 1) ? rtc_pkg::SIZE_W'($urandom_range(1024, 2047)) :
                                      rtc_pkg::SIZE_W'($urandom_range(1, 12));
        pick = $urandom_range(0, 19);
        v.image_height = (pick == 0) ? rtc_pkg::SIZE_W'(0) :
                         (pick == 1) ? rtc_pkg::SIZE_W'($urandom_range(1024, 2047)) :
                                       rtc_pkg::SIZE_W'($urandom_range(1, 10));
        pick = $urandom_range(0, 9);
        v.roi_left = (pick == 0) ? rtc_pkg::OFS_W'(1023) :
                     (pick == 1) ? rtc_pkg::OFS_W'($urandom_range(0, 1023)) :
                                   rtc_pkg::OFS_W'($urandom_range(0, 8));
        pick = $urandom_range(0, 9);
        v.roi_top = (pick == 0) ? rtc_pkg::OFS_W'(1023) :
                    (pick == 1) ? rtc_pkg::OFS_W'($urandom_range(0, 1023)) :
                                  rtc_pkg::OFS_W'($urandom_range(0, 6));
        pick = $urandom_range(0, 9);
        v.roi_width = (pick == 0) ? rtc_pkg::SIZE_W'(0) :
                      (pick == 1) ? rtc_pkg::SIZE_W'(1024) :
                      (pick == 2) ? rtc_pkg::SIZE_W'($urandom_range(0, 2047)) :
                                    rtc_pkg::SIZE_W'($urandom_range(1, 10));
        pick = $urandom_range(0, 9);
        v.roi_height = (pick == 0) ? rtc_pkg::SIZE_W'(0) :
                       (pick == 1) ? rtc_pkg::SIZE_W'(1024) :
                       (pick == 2) ? rtc_pkg::SIZE_W'($urandom_range(0, 2047)) :
                                     rtc_pkg::SIZE_W'($urandom_range(1, 10));
        pick = $urandom_range(0, 9);
        v.level = (pick == 0) ? rtc_pkg::LEVEL_W'(0) :
                  (pick == 1) ? rtc_pkg::LEVEL_W'(255) :
                                rtc_pkg::LEVEL_W'($urandom_range(60, 200));
        return v;
    endfunction

    initial
    begin
        int unsigned wf;
        int unsigned hf;
        int          len;

        pix_if.valid <= 1'b0;
        pix_if.payload <= '0;
        cfg_we <= 1'b0;
        cfg_index <= rtc_pkg::REG_IMAGE_WIDTH;
        cfg_data <= '0;
        shadow = '{rtc_pkg::RST_IMAGE_WIDTH, rtc_pkg::RST_IMAGE_HEIGHT,
                   rtc_pkg::RST_ROI_LEFT, rtc_pkg::RST_ROI_TOP,
                   rtc_pkg::RST_ROI_WIDTH, rtc_pkg::RST_ROI_HEIGHT,
                   rtc_pkg::RST_LEVEL};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A few pixels under the reset settings, outside their region.
        send_word('{8'd0, 8'd0, 8'd0});
        send_word('{8'd255, 8'd255, 8'd255});
        send_word('{8'd128, 8'd64, 8'd32});
        settle();

        // Small image changed mid-line; pixels on either side of the level.
        write_regs('{image_width: 11'd4, image_height: 11'd2, roi_left: 10'd1, roi_top: 10'd0,
                     roi_width: 11'd2, roi_height: 11'd2, level: 8'd100}, 7'h7F);
        send_word('{8'd255, 8'd255, 8'd255});
        send_word('{8'd101, 8'd101, 8'd101});
        send_word('{8'd100, 8'd100, 8'd100});
        send_word('{8'd102, 8'd101, 8'd100});
        send_word('{8'd0, 8'd0, 8'd0});
        send_word('{8'd255, 8'd0, 8'd255});
        send_word('{8'd100, 8'd101, 8'd101});
        send_word('{8'd0, 8'd255, 8'd0});
        settle();

        // Zero image size acts as one pixel, so every word ends a frame; level at zero.
        write_regs('{image_width: 11'd0, image_height: 11'd0, roi_left: 10'd0, roi_top: 10'd0,
                     roi_width: 11'd1024, roi_height: 11'd1024, level: 8'd0}, 7'h7F);
        send_word('{8'd1, 8'd1, 8'd0});
        send_word('{8'd3, 8'd0, 8'd0});
        send_word('{8'd255, 8'd255, 8'd255});
        settle();

        // Region beyond the image is pulled to the last column and row; level at the top
        // leaves every frame empty.
        write_regs('{image_width: 11'd5, image_height: 11'd3, roi_left: 10'd1023,
                     roi_top: 10'd1023, roi_width: 11'd2047, roi_height: 11'd1024,
                     level: 8'd255}, 7'h7F);
        repeat (5) send_word('{8'd255, 8'd255, 8'd255});
        settle();

        // Random settings, each followed by a run of about one to three frames.
        while (pixels_sent < PIXEL_TARGET)
        begin
            write_regs(make_setting(), 7'($urandom_range(1, 127)));
            wf = (shadow.image_width == 0) ? 1 :
                 (shadow.image_width > MAX_DIM) ? MAX_DIM : shadow.image_width;
            hf = (shadow.image_height == 0) ? 1 :
                 (shadow.image_height > MAX_DIM) ? MAX_DIM : shadow.image_height;
            len = wf * hf * $urandom_range(1, 3);
            if (len > 300)
                len = $urandom_range(40, 300);
            if ($urandom_range(0, 3) == 0)
                len = len + $urandom_range(1, 5);
            send_run(len, $urandom_range(0, 3) != 0);
            settle();
        end

        repeat (100) @(posedge clk);
        if (fail_count == 0 && waiting == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* files.f */
rtl/rtc_pkg.sv
rtl/rtc_stream_if.sv
rtl/rtc_div.sv
rtl/rtc_pixel.sv
rtl/roi_threshold_centroid.sv
bench/rtc_centroid_checker.sv
bench/testbench.sv
